// ===== sv/tgbc_pkg.sv =====
// Shared types and constants for the tile grid box collision resolver.
package tgbc_pkg;

  localparam int DIVIDEND_W = 27;
  localparam int QUOT_W     = 20;
  localparam int MAG_W      = DIVIDEND_W - 8;
  localparam int TILE_W     = 8;
  localparam int GRID_W     = 7;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TILE_WIDTH   = 3'd0,
    CFG_TILE_HEIGHT  = 3'd1,
    CFG_GRID_COLUMNS = 3'd2,
    CFG_GRID_ROWS    = 3'd3
  } cfg_reg_e;

  typedef enum logic {
    ACT_LOAD    = 1'b0,
    ACT_RESOLVE = 1'b1
  } action_e;

endpackage

// ===== sv/tgbc_div.sv =====
// Iterative signed divider of a Q18.8 position by a whole pixel tile size.
module tgbc_div (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    start_i,
  input  logic signed [tgbc_pkg::DIVIDEND_W-1:0]  dividend_i,
  input  logic        [tgbc_pkg::TILE_W-1:0]      divisor_i,
  output logic                                    done_o,
  output logic signed [tgbc_pkg::QUOT_W-1:0]      quot_o
);

  localparam int MW = tgbc_pkg::MAG_W;
  localparam int TW = tgbc_pkg::TILE_W;

  logic [MW-1:0]                       mag_q, mag_d;
  logic [TW-1:0]                       rem_q, rem_d;
  logic [TW-1:0]                       div_q;
  logic [4:0]                          cnt_q;
  logic                                busy_q, neg_q, done_q;
  logic [tgbc_pkg::DIVIDEND_W-1:0]     abs_val;
  logic [TW:0]                         rem_sh;
  logic                                ge;

  assign abs_val = dividend_i[tgbc_pkg::DIVIDEND_W-1] ? 
                   tgbc_pkg::DIVIDEND_W'(-dividend_i) : tgbc_pkg::DIVIDEND_W'(dividend_i);
  assign rem_sh  = {rem_q, mag_q[MW-1]};
  assign ge      = rem_sh >= {1'b0, div_q};
  assign rem_d   = ge ? TW'(rem_sh - {1'b0, div_q}) : rem_sh[TW-1:0];
  assign mag_d   = {mag_q[MW-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_q  <= '0;
      rem_q  <= '0;
      div_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      neg_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        mag_q  <= abs_val[tgbc_pkg::DIVIDEND_W-1:8];
        rem_q  <= '0;
        div_q  <= divisor_i;
        cnt_q  <= '0;
        busy_q <= 1'b1;
        neg_q  <= dividend_i[tgbc_pkg::DIVIDEND_W-1];
      end else if (busy_q) begin
        mag_q <= mag_d;
        rem_q <= rem_d;
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'(MW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});

endmodule

// ===== sv/tile_grid_box_collision_resolve.sv =====
// Top level of the tile grid box collision resolver.
// A load, or a resolve with zero velocity, gives its result in the cycle after acceptance.
// A resolve transaction does four divisions on the shared divider per moving axis,
// plus a read and a check per covered cell of the map scan and a scan set-up per moving axis.
// One transaction is in flight at a time; input is ready the cycle after the result transaction.
// Reset clears the configuration to 16 x 16 pixel tiles on a 64 x 64 grid; the map is not cleared.
module tile_grid_box_collision_resolve #(
  parameter int MAX_CELLS   = 4096,
  parameter int EPSILON_LSB = 3
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [tgbc_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [7:0]                            cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  action_i,
  input  logic [11:0]                           cell_index_i,
  input  logic [31:0]                           cell_gid_i,
  input  logic signed [23:0]                    box_x_i,
  input  logic signed [23:0]                    box_y_i,
  input  logic [15:0]                           box_w_i,
  input  logic [15:0]                           box_h_i,
  input  logic signed [23:0]                    vel_x_i,
  input  logic signed [23:0]                    vel_y_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [23:0]                    fix_x_o,
  output logic signed [23:0]                    fix_y_o
);

  localparam int AW  = $clog2(MAX_CELLS);
  localparam int IXW = 16;
  localparam int DW  = tgbc_pkg::DIVIDEND_W;
  localparam int QW  = tgbc_pkg::QUOT_W;
  localparam int GW  = tgbc_pkg::GRID_W;
  localparam int TW  = tgbc_pkg::TILE_W;
  localparam int PW  = 26;
  localparam int CW  = 28;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_DWAIT, S_SCAN, S_RD, S_CHK, S_FIN, S_OUT
  } state_e;

  function automatic logic signed [23:0] sat24(input logic signed [CW-1:0] v);
    if (v > CW'(8388607)) return 24'sh7FFFFF;
    if (v < -CW'(8388608)) return 24'sh800000;
    return v[23:0];
  endfunction

  state_e                  state_q;
  logic [TW-1:0]           tw_q, th_q;
  logic [GW-1:0]           cols_q, rows_q;
  logic signed [23:0]      x_q, y_q, vx_q, vy_q, fx_q, fy_q;
  logic [15:0]             w_q, h_q;
  logic                    isy_q, hit_q, rd_q, inb_q;
  logic signed [PW-1:0]    lo_q, clo_q;
  logic [1:0]              sel_q;
  logic signed [QW-1:0]    a0_q, a1_q, c0_q, c1_q;
  logic [GW-1:0]           a_q, c_q;
  logic signed [CW-1:0]    best_q;
  logic                    mem_q [MAX_CELLS];

  logic [TW-1:0]           tw_eff, th_eff, t_along, t_cross, divisor;
  logic [15:0]             size, csize;
  logic [GW-1:0]           n_along, n_cross, nsel, row, col;
  logic                    pos;
  logic signed [DW-1:0]    dividend;
  logic                    div_done;
  logic signed [QW-1:0]    quot, nm1;
  logic [IXW-1:0]          idx;
  logic                    in_fire, cfg_fire;
  logic [15:0]             prod;
  logic signed [CW-1:0]    cand, edge_hi, res_full;
  logic                    better;
  logic signed [23:0]      res;
  logic [IXW-1:0]          load_ext;

  assign in_fire  = in_valid_i && in_ready_o;
  assign cfg_fire = cfg_valid_i && cfg_ready_o;

  assign tw_eff  = (tw_q == '0) ? TW'(1) : tw_q;
  assign th_eff  = (th_q == '0) ? TW'(1) : th_q;
  assign size    = isy_q ? h_q : w_q;
  assign csize   = isy_q ? w_q : h_q;
  assign t_along = isy_q ? th_eff : tw_eff;
  assign t_cross = isy_q ? tw_eff : th_eff;
  assign n_along = isy_q ? rows_q : cols_q;
  assign n_cross = isy_q ? cols_q : rows_q;
  assign pos     = isy_q ? !vy_q[23] : !vx_q[23];

  always_comb begin
    unique case (sel_q)
      2'd0: dividend = DW'(lo_q);
      2'd1: dividend = DW'(lo_q) + DW'($signed({1'b0, size})) - DW'(EPSILON_LSB);
      2'd2: dividend = DW'(clo_q);
      default: dividend = DW'(clo_q) + DW'($signed({1'b0, csize})) - DW'(EPSILON_LSB);
    endcase
  end

  assign divisor = sel_q[1] ? t_cross : t_along;
  assign nsel    = sel_q[1] ? n_cross : n_along;
  assign nm1     = $signed({{(QW-GW){1'b0}}, nsel}) - QW'(1);

  tgbc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == S_DIV),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  assign row = isy_q ? a_q : c_q;
  assign col = isy_q ? c_q : a_q;
  assign idx = IXW'(row) * IXW'(cols_q) + IXW'(col);

  assign prod     = ({1'b0, a_q} + (pos ? 8'd0 : 8'd1)) * t_along;
  assign edge_hi  = CW'(lo_q) + CW'($signed({1'b0, size}));
  assign cand     = $signed({4'b0, prod, 8'b0}) - (pos ? edge_hi : CW'(lo_q));
  assign better   = !hit_q || (pos ? (cand > best_q) : (cand < best_q));
  assign res_full = best_q;
  assign res      = hit_q ? sat24(res_full) : 24'sd0;
  assign load_ext = IXW'(cell_index_i);

  always_ff @(posedge clk_i) begin
    if (in_fire && action_i == tgbc_pkg::ACT_LOAD && 17'(cell_index_i) < 17'(MAX_CELLS)) begin
      mem_q[load_ext[AW-1:0]] <= |cell_gid_i[28:0];
    end
    if (state_q == S_RD) begin
      rd_q <= mem_q[idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      tw_q    <= TW'(16);
      th_q    <= TW'(16);
      cols_q  <= GW'(64);
      rows_q  <= GW'(64);
      x_q     <= '0;
      y_q     <= '0;
      vx_q    <= '0;
      vy_q    <= '0;
      w_q     <= '0;
      h_q     <= '0;
      fx_q    <= '0;
      fy_q    <= '0;
      isy_q   <= 1'b0;
      hit_q   <= 1'b0;
      inb_q   <= 1'b0;
      lo_q    <= '0;
      clo_q   <= '0;
      sel_q   <= '0;
      a0_q    <= '0;
      a1_q    <= '0;
      c0_q    <= '0;
      c1_q    <= '0;
      a_q     <= '0;
      c_q     <= '0;
      best_q  <= '0;
    end else begin
      if (cfg_fire) begin
        unique case (cfg_index_i)
          tgbc_pkg::CFG_TILE_WIDTH:   tw_q   <= cfg_data_i;
          tgbc_pkg::CFG_TILE_HEIGHT:  th_q   <= cfg_data_i;
          tgbc_pkg::CFG_GRID_COLUMNS: cols_q <= cfg_data_i[GW-1:0];
          tgbc_pkg::CFG_GRID_ROWS:    rows_q <= cfg_data_i[GW-1:0];
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            fx_q <= '0;
            fy_q <= '0;
            x_q  <= box_x_i;
            y_q  <= box_y_i;
            w_q  <= box_w_i;
            h_q  <= box_h_i;
            vx_q <= vel_x_i;
            vy_q <= vel_y_i;
            sel_q <= '0;
            if (action_i == tgbc_pkg::ACT_LOAD) begin
              state_q <= S_OUT;
            end else if (vel_x_i != '0) begin
              isy_q   <= 1'b0;
              lo_q    <= PW'(box_x_i) + PW'(vel_x_i);
              clo_q   <= PW'(box_y_i);
              state_q <= S_DIV;
            end else if (vel_y_i != '0) begin
              isy_q   <= 1'b1;
              lo_q    <= PW'(box_y_i) + PW'(vel_y_i);
              clo_q   <= PW'(box_x_i);
              state_q <= S_DIV;
            end else begin
              state_q <= S_OUT;
            end
          end
        end
        S_DIV: state_q <= S_DWAIT;
        S_DWAIT: begin
          if (div_done) begin
            unique case (sel_q)
              2'd0: a0_q <= (quot < 0) ? '0 : quot;
              2'd1: a1_q <= (quot > nm1) ? nm1 : quot;
              2'd2: c0_q <= (quot < 0) ? '0 : quot;
              default: c1_q <= (quot > nm1) ? nm1 : quot;
            endcase
            sel_q   <= sel_q + 2'd1;
            state_q <= (sel_q == 2'd3) ? S_SCAN : S_DIV;
          end
        end
        S_SCAN: begin
          hit_q <= 1'b0;
          a_q   <= a0_q[GW-1:0];
          c_q   <= c0_q[GW-1:0];
          state_q <= (a0_q > a1_q || c0_q > c1_q) ? S_FIN : S_RD;
        end
        S_RD: begin
          inb_q   <= 17'(idx) < 17'(MAX_CELLS);
          state_q <= S_CHK;
        end
        S_CHK: begin
          if (inb_q && rd_q) begin
            hit_q <= 1'b1;
            if (better) begin
              best_q <= cand;
            end
          end
          if (c_q == c1_q[GW-1:0]) begin
            c_q <= c0_q[GW-1:0];
            if (a_q == a1_q[GW-1:0]) begin
              state_q <= S_FIN;
            end else begin
              a_q     <= a_q + GW'(1);
              state_q <= S_RD;
            end
          end else begin
            c_q     <= c_q + GW'(1);
            state_q <= S_RD;
          end
        end
        S_FIN: begin
          sel_q <= '0;
          if (!isy_q) begin
            fx_q <= res;
            if (vy_q != '0) begin
              isy_q   <= 1'b1;
              lo_q    <= PW'(y_q) + PW'(vy_q);
              clo_q   <= PW'(x_q) + PW'(res);
              state_q <= S_DIV;
            end else begin
              state_q <= S_OUT;
            end
          end else begin
            fy_q    <= res;
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign fix_x_o     = fx_q;
  assign fix_y_o     = fy_q;

endmodule

// ===== sv/tgbc_chk.sv =====
// Port level checker for the tile grid box collision resolver, with its bind.
module tgbc_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               action_i,
  input logic signed [23:0] vel_x_i,
  input logic signed [23:0] vel_y_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [23:0] fix_x_o,
  input logic signed [23:0] fix_y_o
);

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("Input accepted while a result is pending.");

  a_load_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && action_i == tgbc_pkg::ACT_LOAD)
    |=> (out_valid_o && fix_x_o == '0 && fix_y_o == '0))
    else $error("Load transaction did not give a zero result at once.");

  a_still_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && vel_x_i == '0 && vel_y_i == '0)
    |=> (out_valid_o && fix_x_o == '0 && fix_y_o == '0))
    else $error("Resting box gave a nonzero correction.");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i)
    |=> (out_valid_o && $stable(fix_x_o) && $stable(fix_y_o)))
    else $error("Stalled result changed.");

  a_ready_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i) |=> in_ready_o)
    else $error("Block not ready after result transaction.");

endmodule

bind tile_grid_box_collision_resolve tgbc_chk u_tgbc_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .action_i    (action_i),
  .vel_x_i     (vel_x_i),
  .vel_y_i     (vel_y_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .fix_x_o     (fix_x_o),
  .fix_y_o     (fix_y_o)
);

// ===== verif/tb.sv =====
// Self-checking testbench for the tile grid box collision resolver.
`timescale 1ns / 1ps

module tb;

  localparam int NCELLS = 4096;
  localparam int EPS = 3;
  localparam int WATCHDOG_LIMIT = 60000;

  typedef struct {
    tgbc_pkg::action_e action;
    logic [11:0] cell_index;
    logic [31:0] cell_gid;
    logic signed [23:0] box_x, box_y;
    logic [15:0] box_w, box_h;
    logic signed [23:0] vel_x, vel_y;
  } move_item_t;

  typedef struct {
    logic signed [23:0] fix_x, fix_y;
  } fix_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [tgbc_pkg::CFG_IDX_W-1:0] cfg_index = tgbc_pkg::CFG_TILE_WIDTH;
  logic [7:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic action = tgbc_pkg::ACT_LOAD;
  logic [11:0] cell_index = '0;
  logic [31:0] cell_gid = '0;
  logic signed [23:0] box_x = '0, box_y = '0, vel_x = '0, vel_y = '0;
  logic [15:0] box_w = '0, box_h = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [23:0] fix_x, fix_y;

  tile_grid_box_collision_resolve uut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .action_i(action), .cell_index_i(cell_index), .cell_gid_i(cell_gid),
    .box_x_i(box_x), .box_y_i(box_y), .box_w_i(box_w), .box_h_i(box_h),
    .vel_x_i(vel_x), .vel_y_i(vel_y),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .fix_x_o(fix_x), .fix_y_o(fix_y)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  move_item_t pending_moves[$];
  fix_t expected_fixes[$];
  bit solid_cells[NCELLS];
  bit plan_solid[NCELLS];
  bit plan_written[NCELLS];
  int unsigned m_tile_w = 16, m_tile_h = 16, m_cols = 64, m_rows = 64;
  int mismatches = 0;
  int n_loads = 0, n_resolves = 0, n_fixes = 0, n_phases = 1;
  int idle_cycles = 0;

  function automatic void axis_bounds(input longint lo, input longint size,
                                      input longint cross_lo, input longint cross_size,
                                      input longint t_along, input longint t_cross,
                                      input longint n_along, input longint n_cross,
                                      output longint a0, output longint a1,
                                      output longint c0, output longint c1);
    a0 = lo / (t_along * 256);
    a1 = (lo + size - EPS) / (t_along * 256);
    c0 = cross_lo / (t_cross * 256);
    c1 = (cross_lo + cross_size - EPS) / (t_cross * 256);
    if (a0 < 0) a0 = 0;
    if (c0 < 0) c0 = 0;
    if (a1 > n_along - 1) a1 = n_along - 1;
    if (c1 > n_cross - 1) c1 = n_cross - 1;
  endfunction

  function automatic longint axis_push(longint lo, longint size, bit positive,
                                       longint cross_lo, longint cross_size,
                                       longint t_along, longint t_cross,
                                       longint n_along, longint n_cross, bit is_y,
                                       bit planned);
    longint a0, a1, c0, c1, step, best, cand, idx;
    bit hit;
    axis_bounds(lo, size, cross_lo, cross_size, t_along, t_cross, n_along, n_cross,
                a0, a1, c0, c1);
    step = t_along * 256;
    best = 0;
    hit = 0;
    for (longint a = a0; a <= a1; a++) begin
      for (longint c = c0; c <= c1; c++) begin
        idx = is_y ? a * m_cols + c : c * m_cols + a;
        if (idx >= 0 && idx < NCELLS && (planned ? plan_solid[idx] : solid_cells[idx])) begin
          if (positive) begin
            cand = a * step - (lo + size);
            if (!hit || cand > best) best = cand;
          end else begin
            cand = (a + 1) * step - lo;
            if (!hit || cand < best) best = cand;
          end
          hit = 1;
        end
      end
    end
    if (!hit) return 0;
    if (best > 8388607) return 8388607;
    if (best < -8388608) return -8388608;
    return best;
  endfunction

  function automatic fix_t resolve_move(move_item_t m);
    fix_t r;
    longint tw, th, fx, fy;
    tw = (m_tile_w == 0) ? 1 : m_tile_w;
    th = (m_tile_h == 0) ? 1 : m_tile_h;
    fx = 0;
    fy = 0;
    if (m.action == tgbc_pkg::ACT_LOAD) begin
      solid_cells[m.cell_index] = (m.cell_gid[28:0] != 0);
    end else begin
      if (m.vel_x != 0)
        fx = axis_push(longint'(m.box_x) + m.vel_x, m.box_w, m.vel_x > 0, m.box_y, m.box_h,
                       tw, th, m_cols, m_rows, 1'b0, 1'b0);
      if (m.vel_y != 0)
        fy = axis_push(longint'(m.box_y) + m.vel_y, m.box_h, m.vel_y > 0,
                       longint'(m.box_x) + fx, m.box_w, th, tw, m_rows, m_cols, 1'b1, 1'b0);
    end
    r.fix_x = fx[23:0];
    r.fix_y = fy[23:0];
    return r;
  endfunction

  function automatic move_item_t make_load(int idx, logic [31:0] gid);
    move_item_t m;
    m.action = tgbc_pkg::ACT_LOAD;
    m.cell_index = idx[11:0];
    m.cell_gid = gid;
    m.box_x = $urandom; m.box_y = $urandom;
    m.box_w = $urandom; m.box_h = $urandom;
    m.vel_x = $urandom; m.vel_y = $urandom;
    return m;
  endfunction

  function automatic move_item_t make_resolve(int x, int y, int w, int h, int vx, int vy);
    move_item_t m;
    m.action = tgbc_pkg::ACT_RESOLVE;
    m.cell_index = $urandom;
    m.cell_gid = $urandom;
    m.box_x = x[23:0]; m.box_y = y[23:0];
    m.box_w = w[15:0]; m.box_h = h[15:0];
    m.vel_x = vx[23:0]; m.vel_y = vy[23:0];
    return m;
  endfunction

  function automatic logic [31:0] random_gid();
    case ($urandom_range(0, 3))
      0: return 32'h0;
      1: return {3'($urandom_range(0, 7)), 29'h0};
      default: return $urandom;
    endcase
  endfunction

  function automatic int near_pos(int unsigned tile_px, int unsigned cells);
    int span;
    int unsigned win;
    win = (cells == 0) ? 1 : ((cells > 8) ? 8 : cells);
    span = int'(((tile_px == 0) ? 1 : tile_px) * 256 * win);
    return int'($urandom_range(0, span + 2 * span / 8)) - span / 8;
  endfunction

  function automatic int signed_rand24();
    return int'({{8{1'b0}}, 24'($urandom)}) - 8388608;
  endfunction

  // Cells that a resolve will read are loaded first, so no unwritten cell is ever scanned.
  task automatic queue_load(move_item_t m);
    plan_solid[m.cell_index] = (m.cell_gid[28:0] != 0);
    plan_written[m.cell_index] = 1'b1;
    pending_moves = {pending_moves, m};
  endtask

  task automatic plan_fill(longint lo, longint size, longint cross_lo, longint cross_size,
                           longint t_along, longint t_cross, longint n_along,
                           longint n_cross, bit is_y);
    longint a0, a1, c0, c1, idx;
    axis_bounds(lo, size, cross_lo, cross_size, t_along, t_cross, n_along, n_cross,
                a0, a1, c0, c1);
    for (longint a = a0; a <= a1; a++) begin
      for (longint c = c0; c <= c1; c++) begin
        idx = is_y ? a * m_cols + c : c * m_cols + a;
        if (idx >= 0 && idx < NCELLS && !plan_written[idx])
          queue_load(make_load(int'(idx), random_gid()));
      end
    end
  endtask

  task automatic queue_move(move_item_t m);
    longint tw, th, fx;
    if (m.action == tgbc_pkg::ACT_LOAD) begin
      queue_load(m);
    end else begin
      tw = (m_tile_w == 0) ? 1 : m_tile_w;
      th = (m_tile_h == 0) ? 1 : m_tile_h;
      fx = 0;
      if (m.vel_x != 0) begin
        plan_fill(longint'(m.box_x) + m.vel_x, m.box_w, m.box_y, m.box_h,
                  tw, th, m_cols, m_rows, 1'b0);
        fx = axis_push(longint'(m.box_x) + m.vel_x, m.box_w, m.vel_x > 0, m.box_y, m.box_h,
                       tw, th, m_cols, m_rows, 1'b0, 1'b1);
      end
      if (m.vel_y != 0)
        plan_fill(longint'(m.box_y) + m.vel_y, m.box_h, longint'(m.box_x) + fx, m.box_w,
                  th, tw, m_rows, m_cols, 1'b1);
      pending_moves = {pending_moves, m};
    end
  endtask

  task automatic queue_random(int count);
    move_item_t m;
    int tw, th, vx, vy, li;
    for (int i = 0; i < count; i++) begin
      tw = (m_tile_w == 0) ? 1 : m_tile_w;
      th = (m_tile_h == 0) ? 1 : m_tile_h;
      case ($urandom_range(0, 9))
        0, 1: begin
          li = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NCELLS - 1)
                                           : $urandom_range(0, 1023);
          m = make_load(li, random_gid());
        end
        2: begin
          m = make_resolve(signed_rand24(), signed_rand24(), $urandom_range(0, 65535),
                           $urandom_range(0, 65535), signed_rand24(), signed_rand24());
          if (tw * th < 16) begin
            m.box_w = $urandom_range(0, 2047);
            m.box_h = $urandom_range(0, 2047);
          end
        end
        default: begin
          vx = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, tw * 512) - tw * 256;
          vy = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, th * 512) - th * 256;
          m = make_resolve(near_pos(tw, m_cols), near_pos(th, m_rows),
                           $urandom_range(1, (tw * 768 > 65535) ? 65535 : tw * 768),
                           $urandom_range(1, (th * 768 > 65535) ? 65535 : th * 768),
                           vx, vy);
        end
      endcase
      queue_move(m);
    end
  endtask

  task automatic write_reg(tgbc_pkg::cfg_reg_e idx, logic [7:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      tgbc_pkg::CFG_TILE_WIDTH: m_tile_w = value;
      tgbc_pkg::CFG_TILE_HEIGHT: m_tile_h = value;
      tgbc_pkg::CFG_GRID_COLUMNS: m_cols = value[6:0];
      tgbc_pkg::CFG_GRID_ROWS: m_rows = value[6:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_moves.size() != 0 || expected_fixes.size() != 0 || in_valid)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic run_phase(logic [7:0] tw, logic [7:0] th, logic [7:0] cols,
                           logic [7:0] rows, int count);
    drain();
    write_reg(tgbc_pkg::CFG_TILE_WIDTH, tw);
    write_reg(tgbc_pkg::CFG_TILE_HEIGHT, th);
    write_reg(tgbc_pkg::CFG_GRID_COLUMNS, cols);
    write_reg(tgbc_pkg::CFG_GRID_ROWS, rows);
    n_phases++;
    queue_random(count);
  endtask

  int burst_left = 0, gap_left = 0;

  always @(posedge clk) begin
    move_item_t m;
    bit next_valid;
    if (rst_n) begin
      next_valid = in_valid;
      if (in_valid && in_ready) begin
        m = pending_moves.pop_front();
        expected_fixes = {expected_fixes, resolve_move(m)};
        if (m.action == tgbc_pkg::ACT_LOAD) n_loads++;
        else n_resolves++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_moves.size() != 0) begin
          m = pending_moves[0];
          next_valid = 1'b1;
          action <= m.action;
          cell_index <= m.cell_index;
          cell_gid <= m.cell_gid;
          box_x <= m.box_x; box_y <= m.box_y;
          box_w <= m.box_w; box_h <= m.box_h;
          vel_x <= m.vel_x; vel_y <= m.vel_y;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 30);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
      in_valid <= next_valid;
    end
  end

  int stall_mode = 0, stall_timer = 0;

  always @(posedge clk) begin
    fix_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        n_fixes++;
        if (expected_fixes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result: fix_x %0d fix_y %0d", fix_x, fix_y);
        end else begin
          e = expected_fixes.pop_front();
          if (e.fix_x !== fix_x || e.fix_y !== fix_y) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected fix_x %0d fix_y %0d, got fix_x %0d fix_y %0d",
                       e.fix_x, e.fix_y, fix_x, fix_y);
          end
        end
      end
      if (stall_timer == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_timer = $urandom_range(20, 300);
      end else begin
        stall_timer--;
      end
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) == 0);
        2: out_ready <= ($urandom_range(0, 7) == 0);
        default: out_ready <= (stall_timer % 5 != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired with %0d results outstanding", expected_fixes.size());
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    queue_move(make_load(0, 32'hFFFF_FFFF));
    queue_move(make_load(1, 32'hE000_0000));
    queue_move(make_load(4095, 32'h0000_0001));
    queue_move(make_load(65, 32'h1FFF_FFFF));
    queue_move(make_load(66, 32'h0000_0000));
    queue_move(make_resolve(0, 0, 4096, 4096, 0, 0));
    queue_move(make_resolve(0, 0, 4096, 4096, 256, 0));
    queue_move(make_resolve(4096, 4096, 4096, 4096, -300, 0));
    queue_move(make_resolve(4096, 4096, 4096, 4096, 0, 700));
    queue_move(make_resolve(4096, 4096, 4096, 4096, 0, -700));
    queue_move(make_resolve(8000, 8000, 3, 3, 100, 100));
    queue_move(make_resolve(8000, 8000, 0, 0, -5, -5));
    queue_move(make_resolve(-8388608, -8388608, 65535, 65535, 8388607, 8388607));
    queue_move(make_resolve(8388607, 8388607, 65535, 65535, -8388608, -8388608));
    queue_move(make_resolve(-4096, -4096, 65535, 65535, 4096, -4096));
    queue_move(make_resolve(262000, 262000, 512, 512, 200, 200));
    queue_move(make_resolve(0, 0, 65535, 65535, -8388608, 8388607));
    queue_random(100);

    run_phase(8'd255, 8'd255, 8'd1, 8'd1, 30);
    run_phase(8'd1, 8'd1, 8'd64, 8'd64, 40);
    run_phase(8'd0, 8'd0, 8'd127, 8'd127, 40);
    run_phase(8'd8, 8'd4, 8'd0, 8'd5, 20);
    run_phase(8'd3, 8'd200, 8'd40, 8'd17, 40);
    run_phase(8'd16, 8'd16, 8'd64, 8'd64, 50);
    drain();

    $display("Covered %0d load and %0d resolve transactions over %0d settings.",
             n_loads, n_resolves, n_phases);
    $display("Checked %0d results, %0d mismatches.", n_fixes, mismatches);
    if (mismatches == 0 && expected_fixes.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
